// ----- hw/rtl/pixel_color_delta_filter_defines.svh -----
// ---------------------------------------------------------------------------
// Pixel color delta filter: assertion macros
// Shared concurrent assertion forms used by the filter's RTL.
// ---------------------------------------------------------------------------
`ifndef PIXEL_COLOR_DELTA_FILTER_DEFINES_SVH
`define PIXEL_COLOR_DELTA_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PCDF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_color_delta_filter: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PCDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_color_delta_filter: next-cycle check failed");

`endif

// ----- hw/rtl/pcdf_pkg.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter package
// Types, register indexes and format codes shared by the filter's files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcdf_pkg;

   typedef logic [7:0] byte_type;

   // Configuration register indexes
   localparam logic [7:0] CSR_MODE   = 8'd0;
   localparam logic [7:0] CSR_FORMAT = 8'd1;

   // Mode codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Pixel format codes (code three behaves as four bytes)
   localparam logic [1:0] FMT_GRAY = 2'd0;
   localparam logic [1:0] FMT_BGR  = 2'd1;
   localparam logic [1:0] FMT_BGRA = 2'd2;

   // Index of the final byte of a pixel, per format
   localparam logic [1:0] LAST_GRAY = 2'd0;
   localparam logic [1:0] LAST_BGR  = 2'd2;
   localparam logic [1:0] LAST_BGRA = 2'd3;

   // Control handed to the transform
   typedef struct packed {
      logic       mode;
      logic [1:0] last_idx;
   } xform_ctrl_type;

   function automatic logic [1:0] last_index(input logic [1:0] fmt);
      logic [1:0] idx;
      case (fmt)
         FMT_GRAY: idx = LAST_GRAY;
         FMT_BGR:  idx = LAST_BGR;
         default:  idx = LAST_BGRA;
      endcase
      return idx;
   endfunction

endpackage

// ----- hw/rtl/pcdf_if.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter channel interfaces
// Valid/ready channels for input bytes, result bytes and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcdf_req_if;
   logic                valid;
   logic                ready;
   pcdf_pkg::byte_type  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface pcdf_rsp_if;
   logic                valid;
   logic                ready;
   pcdf_pkg::byte_type  out_byte;
   logic                last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface pcdf_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [7:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/pixel_color_delta_filter.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter
// Groups a byte stream into 1, 3 or 4 byte pixels and delta-codes or decodes them.
// ---------------------------------------------------------------------------
// The block accepts one raw byte per cycle on req_chan. Bytes are held until
// a pixel is complete; the completing byte is transformed in the cycle it is
// accepted and the pixel's 1, 3 or 4 result bytes leave on rsp_chan one per
// cycle starting the next cycle, with last set on the final one. A stream of
// pixels thus runs at one byte in and one byte out per cycle. The completing
// byte of a pixel is taken only when the four-entry result buffer is empty or
// its final byte is being taken in that same cycle, so a stalled output
// holds off the input from the next pixel boundary on. Register writes on
// csr_chan are always accepted and should be made while the block is idle.
`timescale 1ns / 1ps
`include "pixel_color_delta_filter_defines.svh"

module pixel_color_delta_filter (
   input  logic        clock,
   input  logic        reset,
   pcdf_req_if.sink    req_chan,
   pcdf_rsp_if.source  rsp_chan,
   pcdf_csr_if.sink    csr_chan
);

   logic                     mode_ff;
   logic [1:0]               fmt_ff;
   logic [2:0][7:0]          pixel_bytes_ff;
   logic [1:0]               byte_index_ff;
   logic [3:0][7:0]          prev_ff;
   logic [3:0][7:0]          prev_in;
   logic [3:0][7:0]          res_ff;
   logic [3:0][7:0]          res_in;
   logic [2:0]               cnt_ff;
   logic [1:0]               rd_ff;
   logic [1:0]               last_idx;
   logic                     complete;
   logic                     req_fire;
   logic                     push;
   logic                     pop;
   pcdf_pkg::xform_ctrl_type ctrl;

   // Decode format and pixel boundary
   assign last_idx = pcdf_pkg::last_index(fmt_ff);
   assign complete = (byte_index_ff >= last_idx);

   // Handshakes
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !complete || (cnt_ff == 3'd0) ||
                           ((cnt_ff == 3'd1) && rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign push     = req_fire && complete;
   assign pop      = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid    = (cnt_ff != 3'd0);
   assign rsp_chan.out_byte = res_ff[rd_ff];
   assign rsp_chan.last     = (cnt_ff == 3'd1);

   // Transform the completed pixel
   assign ctrl.mode     = mode_ff;
   assign ctrl.last_idx = last_idx;

   pcdf_xform u_xform (
      .ctrl        (ctrl),
      .pixel_bytes (pixel_bytes_ff),
      .in_byte     (req_chan.in_byte),
      .prev        (prev_ff),
      .result      (res_in),
      .prev_next   (prev_in)
   );

   // Write configuration registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcdf_pkg::MODE_ENCODE;
         fmt_ff  <= pcdf_pkg::FMT_BGR;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            pcdf_pkg::CSR_MODE:   mode_ff <= csr_chan.data[0];
            pcdf_pkg::CSR_FORMAT: fmt_ff  <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   // Hold pixel bytes and advance the byte index
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 2'd0;
         prev_ff       <= '0;
      end else if (req_fire) begin
         if (complete) begin
            byte_index_ff <= 2'd0;
            prev_ff       <= prev_in;
         end else begin
            byte_index_ff <= byte_index_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !complete) begin
         pixel_bytes_ff[byte_index_ff] <= req_chan.in_byte;
      end
   end

   // Load the result buffer on a completed pixel, drain one byte per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         rd_ff  <= 2'd0;
      end else if (push) begin
         cnt_ff <= {1'b0, last_idx} + 3'd1;
         rd_ff  <= 2'd0;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 3'd1;
         rd_ff  <= rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= res_in;
      end
   end

   // Checks
   `PCDF_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 3'd4)
   `PCDF_ASSERT_NOW(a_no_overrun, clock, reset, push,
                    (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && pop))
   `PCDF_ASSERT_NEXT(a_push_loads, clock, reset, push,
                     rsp_chan.valid && (rd_ff == 2'd0))
   `PCDF_ASSERT_NEXT(a_drain_empty, clock, reset, pop && rsp_chan.last && !push,
                     !rsp_chan.valid)

endmodule

// ----- hw/rtl/pcdf_xform.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter transform
// Forward or inverse green decorrelation and delta for one completed pixel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcdf_xform (
   input  pcdf_pkg::xform_ctrl_type  ctrl,
   input  logic [2:0][7:0]           pixel_bytes,
   input  pcdf_pkg::byte_type        in_byte,
   input  logic [3:0][7:0]           prev,
   output logic [3:0][7:0]           result,
   output logic [3:0][7:0]           prev_next
);

   logic [7:0] px0, px1, px2, px3;
   logic [7:0] x, y, z;

   // Assemble the pixel: the incoming byte fills the final slot
   always_comb begin
      px0 = pixel_bytes[0];
      px1 = pixel_bytes[1];
      px2 = pixel_bytes[2];
      px3 = in_byte;
      case (ctrl.last_idx)
         pcdf_pkg::LAST_GRAY: px0 = in_byte;
         pcdf_pkg::LAST_BGR:  px2 = in_byte;
         default: ;
      endcase
   end

   // Forward color transform
   assign x = px1;
   assign y = px1 - px2;
   assign z = px1 - px0;

   // Compute results and the next previous values
   always_comb begin
      result    = '0;
      prev_next = prev;
      if (ctrl.last_idx == pcdf_pkg::LAST_GRAY) begin
         if (ctrl.mode == pcdf_pkg::MODE_ENCODE) begin
            result[0]    = px0 - prev[0];
            prev_next[0] = px0;
         end else begin
            prev_next[0] = prev[0] + px0;
            result[0]    = prev_next[0];
         end
      end else if (ctrl.mode == pcdf_pkg::MODE_ENCODE) begin
         result[0]    = x - prev[0];
         result[1]    = y - prev[1];
         result[2]    = z - prev[2];
         prev_next[0] = x;
         prev_next[1] = y;
         prev_next[2] = z;
         if (ctrl.last_idx == pcdf_pkg::LAST_BGRA) begin
            result[3]    = px3 - prev[3];
            prev_next[3] = px3;
         end
      end else begin
         prev_next[0] = prev[0] + (px0 - px2);
         prev_next[1] = prev[1] + px0;
         prev_next[2] = prev[2] + (px0 - px1);
         result[0]    = prev_next[0];
         result[1]    = prev_next[1];
         result[2]    = prev_next[2];
         if (ctrl.last_idx == pcdf_pkg::LAST_BGRA) begin
            prev_next[3] = prev[3] + px3;
            result[3]    = prev_next[3];
         end
      end
   end

endmodule

// ----- test/pixel_color_delta_filter_checker.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter checker
// Watches the byte, result and register channels, predicts every result
// byte from its own copy of the filter state and compares it in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_color_delta_filter_checker (
   input  logic  clock,
   input  logic  reset,
   pcdf_req_if   req_chan,
   pcdf_rsp_if   rsp_chan,
   pcdf_csr_if   csr_chan,
   output int    mismatch_count,
   output int    bytes_due,
   output int    bytes_checked
);

   typedef struct packed {
      pcdf_pkg::byte_type value;
      logic               last;
   } coded_byte_type;

   // Result bytes predicted but not yet seen on the output
   coded_byte_type coded_due[$];

   // Predictor copy of the registers and the filter state
   logic               mode_q;
   logic [1:0]         format_q;
   pcdf_pkg::byte_type held_bytes[3];
   logic [1:0]         held_count;
   pcdf_pkg::byte_type prev_vals[4];

   function automatic int pixel_size(input logic [1:0] fmt);
      case (fmt)
         pcdf_pkg::FMT_GRAY: return 1;
         pcdf_pkg::FMT_BGR:  return 3;
         default:            return 4;
      endcase
   endfunction

   task automatic queue_byte(input pcdf_pkg::byte_type value, input logic is_last);
      coded_byte_type entry;
      entry.value = value;
      entry.last  = is_last;
      coded_due.push_back(entry);
   endtask

   // Take one raw byte; once a pixel completes, queue its coded bytes
   task automatic filter_pixel_byte(input pcdf_pkg::byte_type b);
      pcdf_pkg::byte_type px[4];
      pcdf_pkg::byte_type x, y, z;
      int                 size;
      size = pixel_size(format_q);
      if (int'(held_count) + 1 < size) begin
         held_bytes[held_count] = b;
         held_count = held_count + 2'd1;
      end else begin
         // The incoming byte fills the last slot, the rest come from the hold
         for (int i = 0; i + 1 < size; i++) px[i] = held_bytes[i];
         px[size - 1] = b;
         held_count = 2'd0;
         if (size == 1) begin
            if (mode_q == pcdf_pkg::MODE_ENCODE) begin
               queue_byte(px[0] - prev_vals[0], 1'b1);
               prev_vals[0] = px[0];
            end else begin
               prev_vals[0] = prev_vals[0] + px[0];
               queue_byte(prev_vals[0], 1'b1);
            end
         end else if (mode_q == pcdf_pkg::MODE_ENCODE) begin
            // Decorrelate against green, then delta against the last pixel
            x = px[1];
            y = px[1] - px[2];
            z = px[1] - px[0];
            queue_byte(x - prev_vals[0], 1'b0);
            queue_byte(y - prev_vals[1], 1'b0);
            queue_byte(z - prev_vals[2], size == 3);
            prev_vals[0] = x;
            prev_vals[1] = y;
            prev_vals[2] = z;
            if (size == 4) begin
               queue_byte(px[3] - prev_vals[3], 1'b1);
               prev_vals[3] = px[3];
            end
         end else begin
            // Accumulate the deltas back into B, G, R
            prev_vals[0] = prev_vals[0] + pcdf_pkg::byte_type'(px[0] - px[2]);
            prev_vals[1] = prev_vals[1] + px[0];
            prev_vals[2] = prev_vals[2] + pcdf_pkg::byte_type'(px[0] - px[1]);
            queue_byte(prev_vals[0], 1'b0);
            queue_byte(prev_vals[1], 1'b0);
            queue_byte(prev_vals[2], size == 3);
            if (size == 4) begin
               prev_vals[3] = prev_vals[3] + px[3];
               queue_byte(prev_vals[3], 1'b1);
            end
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      bytes_due      = 0;
      bytes_checked  = 0;
   end

   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         mode_q     = pcdf_pkg::MODE_ENCODE;
         format_q   = pcdf_pkg::FMT_BGR;
         held_count = 2'd0;
         for (int i = 0; i < 4; i++) prev_vals[i] = 8'h00;
         coded_due.delete();
      end else begin
         // Compare each result transaction with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            bytes_checked++;
            if (coded_due.size() == 0) begin
               $error("unexpected result: out_byte %02h last %0b",
                      rsp_chan.out_byte, rsp_chan.last);
               mismatch_count++;
            end else begin
               want = coded_due.pop_front();
               if (rsp_chan.out_byte !== want.value) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.value, rsp_chan.out_byte);
                  mismatch_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b",
                         want.last, rsp_chan.last);
                  mismatch_count++;
               end
            end
         end
         // Track register writes; unused indexes are dropped
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               pcdf_pkg::CSR_MODE:   mode_q   = csr_chan.data[0];
               pcdf_pkg::CSR_FORMAT: format_q = csr_chan.data[1:0];
               default:              ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) filter_pixel_byte(req_chan.in_byte);
      end
      bytes_due = coded_due.size();
   end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// Pixel color delta filter testbench
// Drives directed and random byte streams through every mode and pixel
// format, with random gaps and output stalls; the checker judges results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int         HALF_PERIOD   = 4;
   localparam int         RESET_CYCLES  = 7;
   localparam int         TOTAL_BYTES   = 330;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         IDLE_LIMIT    = 2000;
   localparam int         MAX_GAP       = 10;
   // Format code three decodes as four-byte pixels
   localparam logic [1:0] FMT_BGRA_ALT  = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;
   int   bytes_sent = 0;
   int   reg_writes = 0;
   int   idle_cycles = 0;
   int   mismatch_count;
   int   bytes_due;
   int   bytes_checked;

   pcdf_req_if req_chan ();
   pcdf_rsp_if rsp_chan ();
   pcdf_csr_if csr_chan ();

   pixel_color_delta_filter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pixel_color_delta_filter_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .mismatch_count (mismatch_count),
      .bytes_due      (bytes_due),
      .bytes_checked  (bytes_checked)
   );

   always #HALF_PERIOD clock = ~clock;

   // Drop the run if no transaction moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, bytes_due);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Result side: unless steady, stall a random number of cycles before each transaction
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_byte(input pcdf_pkg::byte_type value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.in_byte = value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid = 1'b0;
      reg_writes++;
   endtask

   // Hold the input until every predicted byte is out, then let the block settle
   task automatic drain();
      req_chan.valid = 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_list(input pcdf_pkg::byte_type values[$]);
      foreach (values[i]) send_byte(values[i]);
   endtask

   initial begin
      int                 phase_len;
      logic [1:0]         fmt;
      pcdf_pkg::byte_type value;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = 8'h00;
      csr_chan.data    = 8'h00;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Encode BGR from reset: all-zero, all-ones and mixed extremes
      send_list('{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00});
      drain();
      // Format code three behaves as BGRA
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, FMT_BGRA_ALT});
      send_list('{8'hFF, 8'h00, 8'hFF, 8'h80});
      drain();
      // Switch to gray with two bytes held: the next byte completes the pixel
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_BGRA});
      send_list('{8'h12, 8'h34});
      drain();
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_GRAY});
      send_byte(8'h56);
      drain();
      // Switch to BGR with two bytes held: held bytes fill B and G
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_BGRA});
      send_list('{8'h9A, 8'hBC});
      drain();
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_BGR});
      send_byte(8'hDE);
      drain();
      // Decode keeps the encoder's history; unused indexes are ignored
      write_reg(pcdf_pkg::CSR_MODE, {7'd0, pcdf_pkg::MODE_DECODE});
      write_reg(pcdf_pkg::CSR_FORMAT + 8'd1, 8'hFF);
      write_reg(8'hFF, 8'h00);
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_GRAY});
      send_list('{8'hFF, 8'h01});
      drain();
      write_reg(pcdf_pkg::CSR_FORMAT, {6'd0, pcdf_pkg::FMT_BGR});
      send_list('{8'hFF, 8'h00, 8'h01});

      // Random phases; phase boundaries often fall mid-pixel
      for (int phase = 0; bytes_sent < TOTAL_BYTES; phase++) begin
         drain();
         steady = ($urandom_range(0, 3) == 0);
         fmt = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         write_reg(pcdf_pkg::CSR_MODE,
                   {7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))});
         write_reg(pcdf_pkg::CSR_FORMAT, {6'($urandom_range(0, 63)), fmt});
         if ($urandom_range(0, 4) == 0) begin
            write_reg(8'($urandom_range(pcdf_pkg::CSR_FORMAT + 1, 255)),
                      8'($urandom_range(0, 255)));
         end
         phase_len = $urandom_range(8, 40);
         for (int i = 0; i < phase_len; i++) begin
            case ($urandom_range(0, 7))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = 8'($urandom_range(0, 255));
            endcase
            send_byte(value);
            // Once, pause the sender mid-stream until all results are out
            if (phase == 2 && i == phase_len / 2) drain();
         end
      end

      drain();
      steady = 1'b0;
      $display("Covered %0d input bytes and %0d result bytes over %0d register writes,",
               bytes_sent, bytes_checked, reg_writes);
      $display("all pixel formats in encode and decode, mid-pixel format changes included.");
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pcdf_pkg.sv
hw/rtl/pcdf_if.sv
hw/rtl/pcdf_xform.sv
hw/rtl/pixel_color_delta_filter.sv
test/pixel_color_delta_filter_checker.sv
test/tb.sv
